// ----- rtl/ccc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_pkg: shared types and constants for the cell/circle coverage block
// Fixed field widths, class codes, register indexes, sequencer states and the
// request/response structs of the shared squaring unit.
// ----------------------------------------------------------------------------
package ccc_pkg;

  // field widths
  localparam int COORD_W = 32;  // signed Q15.16 coordinate
  localparam int WIDTH_W = 31;  // unsigned Q15.16 cell width
  localparam int DIFF_W  = 34;  // coordinate minus centre, signed
  localparam int SQ_W    = 64;  // squared distance, unsigned Q32.32
  localparam int RSQ_W   = 63;  // radius squared register
  localparam int SUBD_W  = 9;   // sub_divisions register
  localparam int CFG_W   = 63;  // write data, widest register
  localparam int IDX_W   = 2;   // register index
  localparam int COUNT_W = 17;  // coverage count

  localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;

  // register indexes
  localparam logic [IDX_W-1:0] REG_CENTER_X      = 2'd0;
  localparam logic [IDX_W-1:0] REG_CENTER_Y      = 2'd1;
  localparam logic [IDX_W-1:0] REG_RADIUS_SQ     = 2'd2;
  localparam logic [IDX_W-1:0] REG_SUB_DIVISIONS = 2'd3;

  // register reset values
  localparam logic [COORD_W-1:0] CENTER_X_RST      = 32'd655360;
  localparam logic [COORD_W-1:0] CENTER_Y_RST      = 32'd131072;
  localparam logic [RSQ_W-1:0]   RADIUS_SQ_RST     = 63'd1073741824;
  localparam logic [SUBD_W-1:0]  SUB_DIVISIONS_RST = 9'd200;

  // cell classes
  typedef enum logic [1:0] {
    CLASS_OUTSIDE = 2'd0,
    CLASS_FULL    = 2'd1,
    CLASS_MIXED   = 2'd2
  } cell_class_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORNER,
    ST_CTEST,
    ST_DIVX,
    ST_DIVY,
    ST_FILL,
    ST_COLA,
    ST_COLB,
    ST_ROWS,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // squaring unit request and response
  typedef struct packed {
    logic              valid;
    logic [DIFF_W-1:0] diff;
  } sq_req_t;

  typedef struct packed {
    logic            valid;
    logic [SQ_W-1:0] sq;
  } sq_rsp_t;

endpackage

// ----- rtl/cell_circle_coverage_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_circle_coverage_top: classifies a mesh cell against a circle
// Corner test, then for cells across the edge an N by N sub-square count.
// ----------------------------------------------------------------------------
// A cell is taken when start is high and busy is low; busy then stays high
// until the result is ready, and done is high for exactly one cycle with
// coverage_count and cell_class. The receiver cannot stall, so the result
// must be taken in that cycle; the next start may be given in the same cycle.
// Cells outside or fully inside need four corner squares through the shared
// squaring unit and a corner test in the point tester. A mixed cell adds two
// step divisions, squares the sub-square corner coordinates into two RAMs and
// scans the grid, one pair of adjacent columns of N+1 points per pass through
// the two-lane point tester. Configuration writes are taken at any cycle with
// wr_en high and should be given only while busy is low.
// ----------------------------------------------------------------------------
module cell_circle_coverage_top #(
  parameter int MAX_SUBDIVISIONS = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write port
  input  logic                                 wr_en,
  input  logic [ccc_pkg::IDX_W-1:0]            wr_index,
  input  logic [ccc_pkg::CFG_W-1:0]            wr_data,
  // command
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [ccc_pkg::COORD_W-1:0]   cell_x_low,
  input  logic signed [ccc_pkg::COORD_W-1:0]   cell_y_low,
  input  logic [ccc_pkg::WIDTH_W-1:0]          cell_x_width,
  input  logic [ccc_pkg::WIDTH_W-1:0]          cell_y_width,
  // result
  output logic                                 done,
  output logic [ccc_pkg::COUNT_W-1:0]          coverage_count,
  output logic [1:0]                           cell_class
);

  localparam int NW    = $clog2(MAX_SUBDIVISIONS + 1);
  localparam int DEPTH = MAX_SUBDIVISIONS + 1;
  localparam int DW    = ccc_pkg::DIFF_W;
  localparam int SW    = ccc_pkg::SQ_W;

  // configuration registers
  logic signed [ccc_pkg::COORD_W-1:0] center_x;
  logic signed [ccc_pkg::COORD_W-1:0] center_y;
  logic [ccc_pkg::RSQ_W-1:0]          radius_squared;
  logic [ccc_pkg::SUBD_W-1:0]         sub_divisions;
  logic [NW-1:0]                      n_eff;

  // sequencer
  ccc_pkg::state_t state;
  ccc_pkg::state_t state_next;
  logic            div_start;

  // cell registers
  logic signed [DW-1:0]               dx0;
  logic signed [DW-1:0]               dx1;
  logic signed [DW-1:0]               dy0;
  logic signed [DW-1:0]               dy1;
  logic [ccc_pkg::WIDTH_W-1:0]        wx;
  logic [ccc_pkg::WIDTH_W-1:0]        wy;
  logic [NW-1:0]                      n_q;

  // corner phase
  logic [1:0]                         ci;
  logic [1:0]                         cw;
  logic                               iss_done;
  logic [SW-1:0]                      csq [4];
  logic                               ct;
  logic [2:0]                         hits;
  logic [2:0]                         hit_total;
  logic [31:0]                        full_sq;
  logic [ccc_pkg::COUNT_W-1:0]        full_count;

  // step division
  logic                               div_done;
  logic [ccc_pkg::WIDTH_W-1:0]        div_quot;
  logic [ccc_pkg::WIDTH_W-1:0]        div_dividend;
  logic [ccc_pkg::WIDTH_W-1:0]        sx;
  logic [ccc_pkg::WIDTH_W-1:0]        sy;

  // corner coordinate fill
  logic signed [DW-1:0]               acc;
  logic [NW-1:0]                      fk;
  logic                               fsel;
  logic [NW-1:0]                      wk;
  logic                               wsel;
  logic [DW-1:0]                      corner_diff;
  ccc_pkg::sq_req_t                   sq_req;
  ccc_pkg::sq_rsp_t                   sq_rsp;
  logic                               col_we;
  logic                               row_we;

  // grid scan
  logic [NW-1:0]                      l;
  logic [NW-1:0]                      m;
  logic [NW-1:0]                      col_raddr;
  logic [SW-1:0]                      col_rdata;
  logic [SW-1:0]                      row_rdata;
  logic [SW-1:0]                      col_lo;
  logic                               p_v;
  logic                               p_first;
  logic                               prev_a;
  logic                               prev_b;

  // point tester lanes
  logic [SW-1:0]                      lane_a_col;
  logic [SW-1:0]                      lane_b_col;
  logic [SW-1:0]                      lane_row;
  logic                               hit_a;
  logic                               hit_b;

  // result
  logic [ccc_pkg::COUNT_W-1:0]        count;
  ccc_pkg::cell_class_t               cls;

  // strict inside test; a sum of saturated squares never passes
  function automatic logic point_inside(input logic [SW-1:0] a,
                                        input logic [SW-1:0] b,
                                        input logic [ccc_pkg::RSQ_W-1:0] r);
    logic [SW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s < {2'b00, r};
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x       <= ccc_pkg::CENTER_X_RST;
      center_y       <= ccc_pkg::CENTER_Y_RST;
      radius_squared <= ccc_pkg::RADIUS_SQ_RST;
      sub_divisions  <= ccc_pkg::SUB_DIVISIONS_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        ccc_pkg::REG_CENTER_X:      center_x       <= wr_data[ccc_pkg::COORD_W-1:0];
        ccc_pkg::REG_CENTER_Y:      center_y       <= wr_data[ccc_pkg::COORD_W-1:0];
        ccc_pkg::REG_RADIUS_SQ:     radius_squared <= wr_data[ccc_pkg::RSQ_W-1:0];
        ccc_pkg::REG_SUB_DIVISIONS: sub_divisions  <= wr_data[ccc_pkg::SUBD_W-1:0];
        default: ;
      endcase
    end
  end

  // N clamped to 1..MAX_SUBDIVISIONS
  always_comb begin
    if (sub_divisions == '0) begin
      n_eff = NW'(1);
    end else if (32'(sub_divisions) > 32'(MAX_SUBDIVISIONS)) begin
      n_eff = NW'(MAX_SUBDIVISIONS);
    end else begin
      n_eff = NW'(sub_divisions);
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ccc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // corner test sum and full count
  assign hit_total  = hits + {2'b00, hit_a} + {2'b00, hit_b};
  assign full_sq    = 32'(n_q) * 32'(n_q);
  assign full_count = (full_sq > 32'(ccc_pkg::COUNT_MAX)) ? ccc_pkg::COUNT_MAX
                                                          : full_sq[ccc_pkg::COUNT_W-1:0];

  // next state and sequencer strobes
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      ccc_pkg::ST_IDLE: begin
        if (start) state_next = ccc_pkg::ST_CORNER;
      end
      ccc_pkg::ST_CORNER: begin
        if (sq_rsp.valid && cw == 2'd3) state_next = ccc_pkg::ST_CTEST;
      end
      ccc_pkg::ST_CTEST: begin
        if (ct) begin
          if (hit_total == 3'd0 || hit_total == 3'd4) begin
            state_next = ccc_pkg::ST_FINISH;
          end else begin
            state_next = ccc_pkg::ST_DIVX;
            div_start  = 1'b1;
          end
        end
      end
      ccc_pkg::ST_DIVX: begin
        if (div_done) begin
          state_next = ccc_pkg::ST_DIVY;
          div_start  = 1'b1;
        end
      end
      ccc_pkg::ST_DIVY: begin
        if (div_done) state_next = ccc_pkg::ST_FILL;
      end
      ccc_pkg::ST_FILL: begin
        if (sq_rsp.valid && wsel && wk == n_q) state_next = ccc_pkg::ST_COLA;
      end
      ccc_pkg::ST_COLA: state_next = ccc_pkg::ST_COLB;
      ccc_pkg::ST_COLB: state_next = ccc_pkg::ST_ROWS;
      ccc_pkg::ST_ROWS: begin
        if (m == n_q) begin
          state_next = (l == n_q - NW'(1)) ? ccc_pkg::ST_DRAIN : ccc_pkg::ST_COLA;
        end
      end
      ccc_pkg::ST_DRAIN:  state_next = ccc_pkg::ST_FINISH;
      ccc_pkg::ST_FINISH: state_next = ccc_pkg::ST_IDLE;
      default:            state_next = ccc_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state != ccc_pkg::ST_IDLE);

  // squaring unit feed: four cell corners, then the sub-square coordinates
  always_comb begin
    case (ci)
      2'd0:    corner_diff = dx0;
      2'd1:    corner_diff = dx1;
      2'd2:    corner_diff = dy0;
      default: corner_diff = dy1;
    endcase
  end

  assign sq_req.valid = !iss_done &&
                        (state == ccc_pkg::ST_CORNER || state == ccc_pkg::ST_FILL);
  assign sq_req.diff  = (state == ccc_pkg::ST_CORNER) ? corner_diff : acc;

  ccc_square u_square (
    .clk (clk),
    .rst (rst),
    .req (sq_req),
    .rsp (sq_rsp)
  );

  // step division, x then y
  assign div_dividend = (state == ccc_pkg::ST_DIVX) ? wy : wx;

  ccc_divider #(
    .DIVIDEND_W (ccc_pkg::WIDTH_W),
    .DIVISOR_W  (NW)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (n_q),
    .done     (div_done),
    .quotient (div_quot)
  );

  // column and row squared-distance stores
  assign col_we    = sq_rsp.valid && state == ccc_pkg::ST_FILL && !wsel;
  assign row_we    = sq_rsp.valid && state == ccc_pkg::ST_FILL && wsel;
  assign col_raddr = (state == ccc_pkg::ST_COLA) ? l : (l + NW'(1));

  ccc_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (wk),
    .wdata (sq_rsp.sq),
    .raddr (col_raddr),
    .rdata (col_rdata)
  );

  ccc_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (wk),
    .wdata (sq_rsp.sq),
    .raddr (m),
    .rdata (row_rdata)
  );

  // two-lane point tester, shared by the corner test and the grid scan
  always_comb begin
    if (state == ccc_pkg::ST_CTEST) begin
      lane_a_col = csq[0];
      lane_b_col = csq[1];
      lane_row   = ct ? csq[3] : csq[2];
    end else begin
      lane_a_col = col_lo;
      lane_b_col = col_rdata;
      lane_row   = row_rdata;
    end
  end

  assign hit_a = point_inside(lane_a_col, lane_row, radius_squared);
  assign hit_b = point_inside(lane_b_col, lane_row, radius_squared);

  // scan pipeline valid: row data arrives in the cycle after its address
  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else begin
      p_v <= (state == ccc_pkg::ST_ROWS);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    p_first <= (m == '0);

    // count a sub-square when both lanes hit on this row and the previous one
    if (p_v) begin
      prev_a <= hit_a;
      prev_b <= hit_b;
      if (!p_first && hit_a && hit_b && prev_a && prev_b &&
          count != ccc_pkg::COUNT_MAX) begin
        count <= count + 1'b1;
      end
    end

    case (state)
      ccc_pkg::ST_IDLE: begin
        if (start) begin
          dx0      <= DW'(cell_x_low) - DW'(center_x);
          dx1      <= DW'(cell_x_low) + DW'(cell_x_width) - DW'(center_x);
          dy0      <= DW'(cell_y_low) - DW'(center_y);
          dy1      <= DW'(cell_y_low) + DW'(cell_y_width) - DW'(center_y);
          wx       <= cell_x_width;
          wy       <= cell_y_width;
          n_q      <= n_eff;
          ci       <= '0;
          cw       <= '0;
          iss_done <= 1'b0;
          ct       <= 1'b0;
          hits     <= '0;
        end
      end
      ccc_pkg::ST_CORNER: begin
        if (!iss_done) begin
          ci <= ci + 1'b1;
          if (ci == 2'd3) iss_done <= 1'b1;
        end
        if (sq_rsp.valid) begin
          csq[cw] <= sq_rsp.sq;
          cw      <= cw + 1'b1;
        end
      end
      ccc_pkg::ST_CTEST: begin
        ct   <= 1'b1;
        hits <= hit_total;
        if (ct) begin
          count <= (hit_total == 3'd4) ? full_count : '0;
          if (hit_total == 3'd0) begin
            cls <= ccc_pkg::CLASS_OUTSIDE;
          end else if (hit_total == 3'd4) begin
            cls <= ccc_pkg::CLASS_FULL;
          end else begin
            cls <= ccc_pkg::CLASS_MIXED;
          end
        end
      end
      ccc_pkg::ST_DIVX: begin
        if (div_done) sx <= div_quot;
      end
      ccc_pkg::ST_DIVY: begin
        if (div_done) begin
          sy       <= div_quot;
          acc      <= dx0;
          fk       <= '0;
          fsel     <= 1'b0;
          wk       <= '0;
          wsel     <= 1'b0;
          iss_done <= 1'b0;
        end
      end
      ccc_pkg::ST_FILL: begin
        l <= '0;
        m <= '0;
        // issue side: corner coordinates by repeated addition of the step
        if (!iss_done) begin
          if (fk == n_q) begin
            fk <= '0;
            if (!fsel) begin
              fsel <= 1'b1;
              acc  <= dy0;
            end else begin
              iss_done <= 1'b1;
            end
          end else begin
            acc <= acc + (fsel ? DW'(sy) : DW'(sx));
            fk  <= fk + NW'(1);
          end
        end
        // write side
        if (sq_rsp.valid) begin
          if (wk == n_q) begin
            wk   <= '0;
            wsel <= 1'b1;
          end else begin
            wk <= wk + NW'(1);
          end
        end
      end
      ccc_pkg::ST_COLB: begin
        col_lo <= col_rdata;
      end
      ccc_pkg::ST_ROWS: begin
        if (m == n_q) begin
          m <= '0;
          if (l != n_q - NW'(1)) l <= l + NW'(1);
        end else begin
          m <= m + NW'(1);
        end
      end
      default: ;
    endcase
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ccc_pkg::ST_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ccc_pkg::ST_FINISH) begin
      coverage_count <= count;
      cell_class     <= cls;
    end
  end

endmodule

// ----- rtl/ccc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ccc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 257,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/ccc_square.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_square: shared saturating squarer
// Two-stage pipeline: magnitude and range check, then a 32x32 multiply.
// A magnitude of 2^32 or more gives all ones.
// ----------------------------------------------------------------------------
module ccc_square (
  input  logic             clk,
  input  logic             rst,
  input  ccc_pkg::sq_req_t req,
  output ccc_pkg::sq_rsp_t rsp
);

  logic [ccc_pkg::DIFF_W-1:0] mag_full;
  logic                       v1;
  logic                       sat1;
  logic [31:0]                mag1;
  logic                       v2;
  logic [ccc_pkg::SQ_W-1:0]   sq2;

  // absolute value of the difference
  assign mag_full = req.diff[ccc_pkg::DIFF_W-1] ? (~req.diff + 1'b1) : req.diff;

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= req.valid;
      v2 <= v1;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    sat1 <= |mag_full[ccc_pkg::DIFF_W-1:32];
    mag1 <= mag_full[31:0];
    sq2  <= sat1 ? {ccc_pkg::SQ_W{1'b1}} : (64'(mag1) * 64'(mag1));
  end

  assign rsp.valid = v2;
  assign rsp.sq    = sq2;

endmodule

// ----- rtl/ccc_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_divider: restoring divider, one quotient bit per cycle
// done pulses for one cycle once the last quotient bit is in, with
// the quotient held until the next start. The divisor must be non-zero.
// ----------------------------------------------------------------------------
module ccc_divider #(
  parameter int DIVIDEND_W = 31,
  parameter int DIVISOR_W  = 9
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CW = $clog2(DIVIDEND_W);

  logic                  running;
  logic [CW-1:0]         cnt;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  dsor;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;
  logic                  last;

  // one trial subtraction per cycle
  assign trial = {rem, quo[DIVIDEND_W-1]};
  assign ge    = trial >= {1'b0, dsor};
  assign diff  = trial - {1'b0, dsor};
  assign last  = running && cnt == CW'(DIVIDEND_W - 1);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= !start && last;
      if (start) begin
        running <= 1'b1;
      end else if (last) begin
        running <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= '0;
      rem  <= '0;
      quo  <= dividend;
      dsor <= divisor;
    end else if (running) begin
      rem <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo <= {quo[DIVIDEND_W-2:0], ge};
      cnt <= cnt + 1'b1;
    end
  end

  assign quotient = quo;

endmodule

// ----- rtl/ccc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_checker: port-level assertions for cell_circle_coverage_top
// Watches the command and result ports; bound to the top level below.
// ----------------------------------------------------------------------------
module ccc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic [ccc_pkg::COUNT_W-1:0] coverage_count,
  input logic [1:0]                  cell_class
);

  // a result is only shown once the block has gone idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // an accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // an outside cell never reports a count
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (done && cell_class == ccc_pkg::CLASS_OUTSIDE) |-> coverage_count == '0)
    else $error("outside cell with non-zero count");

  // a full cell always reports at least one sub-square
  a_full_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && cell_class == ccc_pkg::CLASS_FULL) |-> coverage_count != '0)
    else $error("full cell with zero count");

endmodule

bind cell_circle_coverage_top ccc_checker u_ccc_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .coverage_count (coverage_count),
  .cell_class     (cell_class)
);
